>>> hdl/asir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asir_pkg;

  // Capacity of one set and index widths
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int VAL_W     = 32;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // input transaction accepted
    logic grab;    // latch value of item i, clear scan counters
    logic scan;    // issue read of item j
    logic wr;      // write rank and order for item i
    logic out_rd;  // read order and rank at position k
    logic out_acc; // result transaction accepted
  } asir_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_j;  // scan index at final item
    logic last_i;  // ranking index at final item
    logic last_k;  // output position at final item
  } asir_sts_t;

endpackage

`default_nettype wire

>>> hdl/asir_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module asir_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire asir_pkg::asir_sts_t sts,
  output asir_pkg::asir_cmd_t     cmd
);
  import asir_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_GRAB  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_WRITE = 8'b0010_0000,
    S_ORD   = 8'b0100_0000,
    S_SHOW  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Handshake outputs follow the state only
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SHOW);

  // Decode commands
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.grab    = (state_r == S_GRAB);
    cmd.scan    = (state_r == S_SCAN);
    cmd.wr      = (state_r == S_WRITE);
    cmd.out_rd  = (state_r == S_ORD);
    cmd.out_acc = (state_r == S_SHOW) && !out_stall;
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid && in_last) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_GRAB;
      S_GRAB:  state_nxt = S_SCAN;
      S_SCAN:  if (sts.last_j) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_WRITE;
      S_WRITE: state_nxt = sts.last_i ? S_ORD : S_FETCH;
      S_ORD:   state_nxt = S_SHOW;
      S_SHOW:  if (!out_stall) state_nxt = sts.last_k ? S_IDLE : S_ORD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/asir_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module asir_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire asir_pkg::asir_cmd_t cmd,
  input  wire asir_pkg::val_t      in_value,
  input  wire logic                in_last,
  output asir_pkg::asir_sts_t      sts,
  output asir_pkg::idx_t           out_position,
  output asir_pkg::idx_t           out_source_index,
  output asir_pkg::idx_t           out_rank_of_item,
  output logic                     out_final_res
);
  import asir_pkg::*;

  // Stores
  val_t val_mem [MAX_ITEMS];
  idx_t ord_mem [MAX_ITEMS];
  idx_t inv_mem [MAX_ITEMS];

  cnt_t cnt_r;
  idx_t i_r, j_r, jd_r, k_r, r_r;
  logic jv_r;
  val_t vi_r, rd_val_r;
  idx_t ord_rd_r, inv_rd_r;

  cnt_t cnt_m1;
  idx_t last_idx;
  idx_t rd_addr;
  logic precede;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign rd_addr  = cmd.scan ? j_r : i_r;

  assign sts.last_j = (j_r == last_idx);
  assign sts.last_i = (i_r == last_idx);
  assign sts.last_k = (k_r == last_idx);

  // Item j sorts before item i: smaller value, or equal value and lower index
  assign precede = (rd_val_r < vi_r) || ((rd_val_r == vi_r) && (jd_r < i_r));

  // Value store: write on load, read for ranking
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r < CNT_W'(MAX_ITEMS))) begin
      val_mem[cnt_r[IDX_W-1:0]] <= in_value;
    end
    rd_val_r <= val_mem[rd_addr];
  end

  // Order and rank stores
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      inv_mem[i_r] <= r_r;
      ord_mem[r_r] <= i_r;
    end
    if (cmd.out_rd) begin
      ord_rd_r <= ord_mem[k_r];
      inv_rd_r <= inv_mem[k_r];
    end
  end

  // Count loaded values, clear after the final result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load && (cnt_r < CNT_W'(MAX_ITEMS))) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.out_acc && sts.last_k) begin
      cnt_r <= '0;
    end
  end

  // Scan pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r <= 1'b0;
    end else begin
      jv_r <= cmd.scan;
    end
  end

  // Ranking and output indexes
  always_ff @(posedge clk) begin
    if (cmd.load && in_last) begin
      i_r <= '0;
      k_r <= '0;
    end
    if (cmd.grab) begin
      vi_r <= rd_val_r;
      j_r  <= '0;
      r_r  <= '0;
    end
    if (cmd.scan) begin
      j_r  <= j_r + IDX_W'(1);
      jd_r <= j_r;
    end
    if (jv_r && precede) begin
      r_r <= r_r + IDX_W'(1);
    end
    if (cmd.wr) begin
      i_r <= i_r + IDX_W'(1);
    end
    if (cmd.out_acc) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  assign out_position     = k_r;
  assign out_source_index = ord_rd_r;
  assign out_rank_of_item = inv_rd_r;
  assign out_final_res    = sts.last_k;

endmodule

`default_nettype wire

>>> hdl/argsort_with_inverse_rank.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_value (s32 Q16.16), in_last
// out      output     out_valid/out_stall  out_position, out_source_index,
//                                          out_rank_of_item, out_final_res
//
// Loading takes one value per cycle. After the last value, ranking steps
// through fetch, grab, scan, drain and write for each of the n held values:
// one value-store read port serves a compare-and-count scan over all n items.
// Each result then passes an order/rank read and a show, held by output stalls.
// rst_n is synchronous, active low; it clears the count and the sequencer.
// in_stall stays high from the last value until the final result is taken.

module argsort_with_inverse_rank (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire asir_pkg::val_t in_value,
  input  wire logic           in_last,
  output logic                out_valid,
  input  wire logic           out_stall,
  output asir_pkg::idx_t      out_position,
  output asir_pkg::idx_t      out_source_index,
  output asir_pkg::idx_t      out_rank_of_item,
  output logic                out_final_res
);
  import asir_pkg::*;

  asir_cmd_t cmd;
  asir_sts_t sts;

  asir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  asir_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .in_last          (in_last),
    .sts              (sts),
    .out_position     (out_position),
    .out_source_index (out_source_index),
    .out_rank_of_item (out_rank_of_item),
    .out_final_res    (out_final_res)
  );

endmodule

`default_nettype wire

>>> hdl/asir_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module asir_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire asir_pkg::val_t       in_value,
  input wire logic                 in_last,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire asir_pkg::idx_t       out_position,
  input wire asir_pkg::idx_t       out_source_index,
  input wire asir_pkg::idx_t       out_rank_of_item,
  input wire logic                 out_final_res
);
  import asir_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) &&
      $stable(out_source_index) && $stable(out_rank_of_item) &&
      $stable(out_final_res))
    else $error("stalled result changed");

  // No input transaction while results drain
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during output");

  // A closing value starts ranking
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall && !out_valid)
    else $error("no ranking after last value");

  // Final result transaction returns the block to loading
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_final_res |=> !in_stall && !out_valid)
    else $error("block not idle after final result");

endmodule

bind argsort_with_inverse_rank asir_checker u_asir_checker (.*);

`default_nettype wire
